>>> sv/chm_pkg.sv
// ----------------------------------------------------------------------------
// chm_pkg
// Shared types for the chained hash map: request codes, controller states,
// and the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package chm_pkg;

	typedef enum logic [1:0] {
		OP_PUT    = 2'd0,
		OP_GET    = 2'd1,
		OP_REMOVE = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HEAD,
		ST_WALK,
		ST_HIT,
		ST_MISS,
		ST_ALLOC,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic clr_en;
		logic start;
		logic head_load;
		logic walk;
		logic hit;
		logic write_val;
		logic unlink;
		logic alloc;
		logic set_full;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic clr_done;
		op_t  op;
		logic head_nil;
		logic key_match;
		logic link_nil;
		logic full;
		logic out_busy;
	} sts_t;

	localparam int IN_DATA_BITS  = 64;
	localparam int OUT_DATA_BITS = 48;
	localparam int FIELD_BITS    = 32;
	localparam int COUNT_BITS    = 7;

endpackage

>>> sv/chm_ram.sv
// ----------------------------------------------------------------------------
// chm_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module chm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> sv/chm_ctrl.sv
// ----------------------------------------------------------------------------
// chm_ctrl
// Request sequencer: clears the bucket table after reset, then walks one
// chain per request and orders the table updates.
// ----------------------------------------------------------------------------
module chm_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  chm_pkg::sts_t sts,
	output chm_pkg::cmd_t cmd
);
	import chm_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (sts.clr_done) state_d = ST_IDLE;
			ST_IDLE:  if (in_valid) state_d = ST_HEAD;
			ST_HEAD: begin
				if (sts.op == OP_NONE) state_d = ST_DONE;
				else if (sts.head_nil) state_d = ST_MISS;
				else state_d = ST_WALK;
			end
			ST_WALK: begin
				if (sts.key_match) state_d = ST_HIT;
				else if (sts.link_nil) state_d = ST_MISS;
			end
			ST_HIT: state_d = ST_DONE;
			ST_MISS: begin
				if (sts.op == OP_PUT && !sts.full) state_d = ST_ALLOC;
				else state_d = ST_DONE;
			end
			ST_ALLOC: state_d = ST_DONE;
			ST_DONE:  if (!sts.out_busy) state_d = ST_IDLE;
			default:  state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_CLEAR: cmd.clr_en = 1'b1;
			ST_IDLE: begin
				in_ready  = 1'b1;
				cmd.start = in_valid;
			end
			ST_HEAD: cmd.head_load = 1'b1;
			ST_WALK: begin
				cmd.hit  = sts.key_match;
				cmd.walk = !sts.key_match;
			end
			ST_HIT: begin
				cmd.write_val = (sts.op == OP_PUT);
				cmd.unlink    = (sts.op == OP_REMOVE);
			end
			ST_MISS:  cmd.set_full = (sts.op == OP_PUT) && sts.full;
			ST_ALLOC: cmd.alloc = 1'b1;
			ST_DONE:  cmd.finish = !sts.out_busy;
			default:  cmd = '0;
		endcase
	end

endmodule

>>> sv/chm_datapath.sv
// ----------------------------------------------------------------------------
// chm_datapath
// Bucket table, entry pool memories, free-slot stack, request registers
// and the output word register.
// ----------------------------------------------------------------------------
module chm_datapath #(
	parameter int BUCKETS    = 16,
	parameter int ENTRIES    = 64,
	parameter int KEY_BITS   = 32,
	parameter int VALUE_BITS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [chm_pkg::IN_DATA_BITS-1:0]  in_data,
	input  logic [1:0]                        in_user,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [chm_pkg::OUT_DATA_BITS-1:0] out_data,
	input  chm_pkg::cmd_t                     cmd,
	output chm_pkg::sts_t                     sts
);
	import chm_pkg::*;

	localparam int BW = $clog2(BUCKETS);
	localparam int IW = $clog2(ENTRIES);
	localparam int LW = $clog2(ENTRIES + 1);
	localparam logic [LW-1:0] NIL = LW'(ENTRIES);

	logic [KEY_BITS-1:0]   in_key;
	logic [VALUE_BITS-1:0] in_val;
	logic [BW-1:0]         in_bkt;

	always_comb begin
		in_key = '0;
		in_val = '0;
		in_bkt = '0;
		for (int i = 0; i < KEY_BITS; i++) begin
			if (i < FIELD_BITS) in_key[i] = in_data[i];
		end
		for (int i = 0; i < VALUE_BITS; i++) begin
			if (i < FIELD_BITS) in_val[i] = in_data[FIELD_BITS + i];
		end
		for (int i = 0; i < BW; i++) begin
			if (i < KEY_BITS && i < FIELD_BITS) in_bkt[i] = in_data[i];
		end
	end

	op_t                   op_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [BW-1:0]         bkt_q;
	logic [LW-1:0]         head_q, cur_q, prev_q, hit_link_q;
	logic                  found_q, status_q;
	logic [VALUE_BITS-1:0] vout_q;
	logic [LW-1:0]         count_q, fresh_q, free_cnt_q;
	logic [BW-1:0]         clr_q;
	logic                  out_valid_q;
	logic [OUT_DATA_BITS-1:0] out_data_q;

	logic [LW-1:0]         head_rd, link_rd, ent_ra, slot;
	logic [KEY_BITS-1:0]   key_rd;
	logic [VALUE_BITS-1:0] val_rd;
	logic [IW-1:0]         free_rd, free_ra;

	logic          head_we, link_we, val_we;
	logic [BW-1:0] head_wa;
	logic [LW-1:0] head_wd, link_wd;
	logic [IW-1:0] link_wa, val_wa;

	assign ent_ra  = cmd.head_load ? head_rd : link_rd;
	assign free_ra = IW'(free_cnt_q - LW'(1));
	assign slot    = (free_cnt_q == '0) ? fresh_q : LW'(free_rd);

	always_comb begin
		head_we = 1'b0;
		head_wa = bkt_q;
		head_wd = slot;
		link_we = 1'b0;
		link_wa = slot[IW-1:0];
		link_wd = head_q;
		val_we  = cmd.write_val || cmd.alloc;
		val_wa  = cmd.alloc ? slot[IW-1:0] : cur_q[IW-1:0];
		priority if (cmd.clr_en) begin
			head_we = 1'b1;
			head_wa = clr_q;
			head_wd = NIL;
		end else if (cmd.alloc) begin
			head_we = 1'b1;
			link_we = 1'b1;
		end else if (cmd.unlink) begin
			if (prev_q == NIL) begin
				head_we = 1'b1;
				head_wd = hit_link_q;
			end else begin
				link_we = 1'b1;
				link_wa = prev_q[IW-1:0];
				link_wd = hit_link_q;
			end
		end
	end

	chm_ram #(.WIDTH(LW), .DEPTH(BUCKETS)) u_head_ram (
		.clk(clk), .we(head_we), .waddr(head_wa), .wdata(head_wd),
		.raddr(in_bkt), .rdata(head_rd)
	);

	chm_ram #(.WIDTH(KEY_BITS), .DEPTH(ENTRIES)) u_key_ram (
		.clk(clk), .we(cmd.alloc), .waddr(slot[IW-1:0]), .wdata(key_q),
		.raddr(ent_ra[IW-1:0]), .rdata(key_rd)
	);

	chm_ram #(.WIDTH(VALUE_BITS), .DEPTH(ENTRIES)) u_val_ram (
		.clk(clk), .we(val_we), .waddr(val_wa), .wdata(val_q),
		.raddr(ent_ra[IW-1:0]), .rdata(val_rd)
	);

	chm_ram #(.WIDTH(LW), .DEPTH(ENTRIES)) u_link_ram (
		.clk(clk), .we(link_we), .waddr(link_wa), .wdata(link_wd),
		.raddr(ent_ra[IW-1:0]), .rdata(link_rd)
	);

	chm_ram #(.WIDTH(IW), .DEPTH(ENTRIES)) u_free_ram (
		.clk(clk), .we(cmd.unlink), .waddr(free_cnt_q[IW-1:0]),
		.wdata(cur_q[IW-1:0]), .raddr(free_ra), .rdata(free_rd)
	);

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			op_q  <= op_t'(in_user);
			key_q <= in_key;
			val_q <= in_val;
			bkt_q <= in_bkt;
		end
		if (cmd.head_load) begin
			head_q <= head_rd;
			cur_q  <= head_rd;
			prev_q <= NIL;
		end
		if (cmd.walk) begin
			prev_q <= cur_q;
			cur_q  <= link_rd;
		end
		if (cmd.hit) begin
			hit_link_q <= link_rd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q    <= 1'b0;
			status_q   <= 1'b0;
			vout_q     <= '0;
			count_q    <= '0;
			fresh_q    <= '0;
			free_cnt_q <= '0;
			clr_q      <= '0;
		end else begin
			if (cmd.clr_en) clr_q <= clr_q + BW'(1);
			if (cmd.start) begin
				found_q  <= 1'b0;
				status_q <= 1'b0;
				vout_q   <= '0;
			end
			if (cmd.hit) begin
				found_q <= 1'b1;
				if (op_q == OP_GET) vout_q <= val_rd;
			end
			if (cmd.set_full) status_q <= 1'b1;
			if (cmd.alloc) begin
				count_q <= count_q + LW'(1);
				if (free_cnt_q == '0) fresh_q <= fresh_q + LW'(1);
				else free_cnt_q <= free_cnt_q - LW'(1);
			end
			if (cmd.unlink) begin
				count_q    <= count_q - LW'(1);
				free_cnt_q <= free_cnt_q + LW'(1);
			end
		end
	end

	logic [OUT_DATA_BITS-1:0] out_word;

	always_comb begin
		out_word    = '0;
		out_word[0] = status_q;
		out_word[1] = found_q;
		for (int i = 0; i < FIELD_BITS; i++) begin
			if (i < VALUE_BITS) out_word[2 + i] = vout_q[i];
		end
		for (int i = 0; i < COUNT_BITS; i++) begin
			if (i < LW) out_word[2 + FIELD_BITS + i] = count_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) out_data_q <= out_word;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_comb begin
		sts           = '0;
		sts.clr_done  = (clr_q == BW'(BUCKETS - 1));
		sts.op        = op_q;
		sts.head_nil  = (head_rd == NIL);
		sts.key_match = (key_rd == key_q);
		sts.link_nil  = (link_rd == NIL);
		sts.full      = (count_q == NIL);
		sts.out_busy  = out_valid_q && !out_ready;
	end

endmodule

>>> sv/chained_hash_map.sv
// ----------------------------------------------------------------------------
// chained_hash_map
// Key-to-value map with separate chaining over a fixed entry pool.
// ----------------------------------------------------------------------------
// After reset the block clears its bucket table, one bucket per cycle, before
// it takes the first request. Each request then reads its bucket head, walks
// the chain entry by entry and ends in a hit or a miss step, with an added
// allocation step for a put that takes a new slot; an unused op code skips the walk.
// The walk reads one entry per cycle from the registered-read pool memories.
// One request is in progress at a time; a finished result waits in the
// output register while the next request is accepted.
module chained_hash_map #(
	parameter int BUCKETS    = 16,
	parameter int ENTRIES    = 64,
	parameter int KEY_BITS   = 32,
	parameter int VALUE_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // key[31:0], value_in[63:32]
	input  logic [1:0]  s_tuser,  // op[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata   // status, found, value_out[33:2], entry_count[40:34]
);
	import chm_pkg::*;

	cmd_t cmd;
	sts_t sts;

	chm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(s_tvalid), .in_ready(s_tready),
		.sts(sts), .cmd(cmd)
	);

	chm_datapath #(
		.BUCKETS(BUCKETS), .ENTRIES(ENTRIES),
		.KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .in_data(s_tdata), .in_user(s_tuser),
		.out_valid(m_tvalid), .out_ready(m_tready), .out_data(m_tdata),
		.cmd(cmd), .sts(sts)
	);

endmodule

>>> sv/chm_checker.sv
// ----------------------------------------------------------------------------
// chm_checker
// Port-level checks of the chained hash map's result words.
// ----------------------------------------------------------------------------
module chm_checker #(
	parameter int ENTRIES = 64
) (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("Result word changed while stalled.");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[40:34] <= 7'(ENTRIES))
		else $error("Entry count exceeds the pool size.");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> !m_tdata[1] && m_tdata[40:34] == 7'(ENTRIES))
		else $error("Full status with a found key or a pool not full.");

	a_miss: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[1] |-> m_tdata[33:2] == 32'd0)
		else $error("Nonzero value on a miss.");

endmodule

bind chained_hash_map chm_checker #(.ENTRIES(ENTRIES)) u_chm_checker (
	.clk(clk), .arst_n(arst_n), .m_tvalid(m_tvalid), .m_tready(m_tready),
	.m_tdata(m_tdata)
);

>>> verif/chained_hash_map_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chained_hash_map_tb
// Drives put, get, remove and unused-op requests into the hash map, predicts each
// response from a chained-pool model of its own, and compares every word.
// ----------------------------------------------------------------------------
module chained_hash_map_tb;
	import chm_pkg::*;

	localparam int NBUCKETS = 16;
	localparam int NSLOTS   = 64;
	localparam int NIL      = NSLOTS;
	localparam int LIMIT    = 20000;

	typedef struct packed {
		logic [6:0]  count;
		logic [31:0] value;
		logic        found;
		logic        status;
	} resp_t;

	class map_scoreboard;
		int          heads [NBUCKETS];
		logic [31:0] keys  [NSLOTS];
		logic [31:0] vals  [NSLOTS];
		int          links [NSLOTS];
		bit          used  [NSLOTS];
		int          held;
		resp_t       pending [$];
		int          errors;

		function new();
			for (int i = 0; i < NBUCKETS; i++) heads[i] = NIL;
			for (int i = 0; i < NSLOTS; i++) begin
				keys[i] = '0; vals[i] = '0; links[i] = NIL; used[i] = 0;
			end
			held = 0;
			errors = 0;
		endfunction

		function void note_request(op_t op, logic [31:0] key, logic [31:0] val);
			int b, cur, prev, hit, pre, steps, slot;
			bit hitb;
			resp_t r;
			r = '0;
			b = int'(key[3:0]);
			cur = heads[b]; prev = NIL; hitb = 0; hit = 0; pre = NIL;
			if (op != OP_NONE) begin
				for (steps = 0; steps < NSLOTS && cur < NSLOTS && !hitb; steps++) begin
					if (keys[cur] == key) begin
						hitb = 1; hit = cur; pre = prev;
					end else begin
						prev = cur; cur = links[cur];
					end
				end
			end
			r.found = hitb;
			case (op)
				OP_PUT: begin
					if (hitb) vals[hit] = val;
					else if (held >= NSLOTS) r.status = 1;
					else begin
						for (slot = 0; slot < NSLOTS && used[slot]; slot++);
						used[slot] = 1; keys[slot] = key; vals[slot] = val;
						links[slot] = heads[b]; heads[b] = slot; held++;
					end
				end
				OP_GET: if (hitb) r.value = vals[hit];
				OP_REMOVE: if (hitb) begin
					if (pre < NSLOTS) links[pre] = links[hit];
					else heads[b] = links[hit];
					links[hit] = NIL; used[hit] = 0; held--;
				end
				default: ;
			endcase
			r.count = 7'(held);
			pending.push_back(r);
		endfunction

		function void check_response(resp_t got);
			resp_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected word %h", $time, got);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.status !== want.status)
				$display("%0t: status exp %0d got %0d", $time, want.status, got.status);
			if (got.found !== want.found)
				$display("%0t: found exp %0d got %0d", $time, want.found, got.found);
			if (got.value !== want.value)
				$display("%0t: value exp %h got %h", $time, want.value, got.value);
			if (got.count !== want.count)
				$display("%0t: count exp %0d got %0d", $time, want.count, got.count);
			if (got !== want) errors++;
		endfunction
	endclass

	logic        clk, arst_n;
	logic        s_tvalid, s_tready, m_tvalid, m_tready;
	logic [63:0] s_tdata;
	logic [1:0]  s_tuser;
	logic [47:0] m_tdata;

	map_scoreboard board;
	logic [31:0] key_pool [16];
	int  idle_cycles;
	bit  hold_off;

	chained_hash_map i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	task automatic send_request(op_t op, logic [31:0] key, logic [31:0] val);
		s_tvalid <= 1;
		s_tuser <= op;
		s_tdata <= {val, key};
		do @(posedge clk); while (!s_tready);
		board.note_request(op, key, val);
	endtask

	task automatic pause(int n);
		s_tvalid <= 0;
		repeat (n) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_key();
		case ($urandom_range(0, 9))
			0: return $urandom();
			1: return {2'($urandom_range(0, 3)), 26'h0, 4'($urandom_range(0, 15))};
			default: return key_pool[$urandom_range(0, 15)];
		endcase
	endfunction

	always @(posedge clk) begin
		if (m_tvalid && m_tready) board.check_response(resp_t'(m_tdata[40:0]));
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		m_tready <= 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off) m_tready <= 0;
			else if ($urandom_range(0, 99) < 60) m_tready <= 1;
			else if ($urandom_range(0, 3) == 0) m_tready <= 0;
			else m_tready <= ($urandom_range(0, 1) == 1);
		end
	end

	initial begin
		int burst, n;
		board = new();
		s_tvalid <= 0; s_tdata <= '0; s_tuser <= OP_NONE;
		arst_n <= 0; hold_off = 0;
		for (int i = 0; i < 16; i++) key_pool[i] = $urandom();
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		send_request(OP_GET, 32'h0, 32'h0);
		send_request(OP_PUT, 32'h0, 32'hFFFF_FFFF);
		send_request(OP_PUT, 32'hFFFF_FFFF, 32'h0);
		send_request(OP_PUT, 32'h10, 32'h1234_5678);
		send_request(OP_PUT, 32'h20, 32'hAAAA_5555);
		send_request(OP_GET, 32'h10, 32'h0);
		send_request(OP_GET, 32'h0, 32'h0);
		send_request(OP_PUT, 32'h10, 32'h5555_AAAA);
		send_request(OP_GET, 32'h10, 32'hDEAD_BEEF);
		send_request(OP_REMOVE, 32'h10, 32'h0);
		send_request(OP_REMOVE, 32'h10, 32'h0);
		send_request(OP_GET, 32'h20, 32'h0);
		send_request(OP_REMOVE, 32'h20, 32'h0);
		send_request(OP_REMOVE, 32'h0, 32'h0);
		send_request(OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(OP_GET, 32'hFFFF_FFFF, 32'h0);

		// Fill the pool past its size to reach the full status, then overwrite.
		for (int i = 0; i < 70; i++) send_request(OP_PUT, 32'h100 + i, $urandom());
		send_request(OP_PUT, 32'h100, 32'h0BAD_F00D);
		send_request(OP_GET, 32'h100, 32'h0);
		for (int i = 69; i >= 0; i--) send_request(OP_REMOVE, 32'h100 + i, 32'h0);

		// Long receiver hold-off while requests keep coming.
		hold_off = 1;
		fork
			begin
				repeat (300) @(posedge clk);
				hold_off = 0;
			end
			for (int i = 0; i < 20; i++) send_request(OP_PUT, $urandom(), $urandom());
		join

		n = 0;
		while (n < 1600) begin
			burst = $urandom_range(1, 24);
			for (int j = 0; j < burst; j++) begin
				case ($urandom_range(0, 19))
					0: send_request(OP_NONE, $urandom(), $urandom());
					1, 2, 3, 4, 5, 6, 7:
						send_request(OP_PUT, pick_key(), $urandom());
					8, 9, 10, 11, 12, 13:
						send_request(OP_GET, pick_key(), $urandom());
					default: send_request(OP_REMOVE, pick_key(), $urandom());
				endcase
				n++;
				if (n % 400 == 0)
					for (int i = 0; i < 16; i++) key_pool[i] = $urandom();
			end
			if ($urandom_range(0, 2) != 0) pause($urandom_range(1, 30));
		end
		s_tvalid <= 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (board.errors == 0 && board.pending.size() == 0) $display("TB_OK");
		else $display("TB_ERROR");
		$finish;
	end
endmodule
